### hw/rtl/hgn_pkg.sv
package hgn_pkg;

    // default line store depth
    localparam int MAX_ROW_LENGTH_DEF = 1024;
    localparam int MAX_ROWS = 4096;

    // field widths
    localparam int HEIGHT_W  = 16;
    localparam int GW_W      = 11;
    localparam int GH_W      = 13;
    localparam int GS_W      = 16;
    localparam int ROW_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // search datapath
    localparam int Q_W    = 15;
    localparam int SRCH_W = 72;
    localparam int STEPS  = 15;
    localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SPACING = 2'd2;

    // reset values
    localparam logic [GW_W-1:0] GW_RESET = 11'd256;
    localparam logic [GH_W-1:0] GH_RESET = 13'd256;
    localparam logic [GS_W-1:0] GS_RESET = 16'd256;

    // one component of the rounding search
    typedef struct packed {
        logic [Q_W-1:0]           q;
        logic signed [SRCH_W-1:0] p;
        logic signed [SRCH_W-1:0] m;
        logic signed [SRCH_W-1:0] rhs;
    } comp_t;

    // flags that ride along the pipeline
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
        logic last;
    } flags_t;

endpackage

### hw/rtl/hgn_if.sv
interface hgn_height_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       height_in;
    modport source (output valid, output height_in, input ready);
    modport sink   (input valid, input height_in, output ready);
endinterface

interface hgn_normal_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       normal_x;
    logic signed [15:0]       normal_y;
    logic [14:0]              normal_z;
    logic                     frame_last;
    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output frame_last, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input frame_last, output ready);
endinterface

interface hgn_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/height_grid_normal_stream_top.sv
// Height grid to unit normal stream.
// Channel height: one signed Q8.8 sample per transaction, row-major order.
// Channel normal: unit normal (Q1.14) of each interior grid point, with
// frame_last set on the last interior point of the frame.
// Channel cfg: register writes (0 width, 1 height, 2 spacing), always ready;
// write only while the block is idle. A size write restarts the frame.
// Throughput: one sample per cycle while the pipeline is not stalled. The
// normal of point (c, r) is computed from the transaction that delivers
// sample (c+1, r+1) and passes through three arithmetic stages after the
// line store read, a 15-stage rounding search (one quotient bit per stage
// for each component) and the output register.
// The two line stores are synchronous memories read at the column counter
// and written back one stage later.
// Reset clears counters, taps, pipeline valids and restores registers
// (256, 256, 256); line store contents stay undefined and are refilled by
// the first two rows of every frame.
// Stall: the whole pipeline holds while a result waits and the last search
// stage is full; otherwise samples keep flowing into the empty slots.
module height_grid_normal_stream_top #(
    parameter int MAX_ROW_LENGTH = hgn_pkg::MAX_ROW_LENGTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hgn_height_if.sink           height,
    hgn_normal_if.source         normal,
    hgn_cfg_if.sink              cfg
);

    localparam int CW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int LW = 14;
    localparam int SW = hgn_pkg::SRCH_W;
    localparam int NS = hgn_pkg::STEPS;
    localparam logic [LW-1:0] MAXW = LW'(MAX_ROW_LENGTH);

    // configuration registers
    logic [hgn_pkg::GW_W-1:0] gw_reg;
    logic [hgn_pkg::GH_W-1:0] gh_reg;
    logic [hgn_pkg::GS_W-1:0] gs_reg;
    logic                     size_wr;

    assign cfg.ready = 1'b1;
    assign size_wr = cfg.valid && (cfg.index == hgn_pkg::REG_GRID_WIDTH ||
                                   cfg.index == hgn_pkg::REG_GRID_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= hgn_pkg::GW_RESET;
            gh_reg <= hgn_pkg::GH_RESET;
            gs_reg <= hgn_pkg::GS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                hgn_pkg::REG_GRID_WIDTH:   gw_reg <= cfg.data[hgn_pkg::GW_W-1:0];
                hgn_pkg::REG_GRID_HEIGHT:  gh_reg <= cfg.data[hgn_pkg::GH_W-1:0];
                hgn_pkg::REG_GRID_SPACING: gs_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [LW-1:0] w_eff;
    logic [LW-1:0] h_eff;
    logic [LW-1:0] gw_ext;
    logic [LW-1:0] gh_ext;

    assign gw_ext = LW'(gw_reg);
    assign gh_ext = LW'(gh_reg);

    always_comb
    begin
        if (gw_ext < 14'd3)
            w_eff = 14'd3;
        else if (gw_ext > MAXW)
            w_eff = MAXW;
        else
            w_eff = gw_ext;
        if (gh_ext < 14'd3)
            h_eff = 14'd3;
        else if (gh_ext > 14'(hgn_pkg::MAX_ROWS))
            h_eff = 14'(hgn_pkg::MAX_ROWS);
        else
            h_eff = gh_ext;
    end

    // pipeline control; the output register loads only when it is empty or its result is taken
    logic          en;
    logic          out_ld;
    logic          acc;
    logic [NS:0]   pv_reg;
    logic          out_valid_reg;

    assign out_ld = !out_valid_reg || normal.ready;
    assign en = out_ld || !pv_reg[NS];
    assign height.ready = en;
    assign acc = height.valid && en;

    // position counters
    logic [CW-1:0]                col_reg;
    logic [hgn_pkg::ROW_W-1:0]    row_reg;
    logic [LW-1:0]                col_inc;
    logic [LW-1:0]                row_inc;

    assign col_inc = LW'(col_reg) + 14'd1;
    assign row_inc = LW'(row_reg) + 14'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (size_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            if (col_inc >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (row_inc >= h_eff) ? '0 : row_inc[hgn_pkg::ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // stage 1: line store read, sample capture
    logic                 v1_reg;
    logic                 p1_reg;
    logic                 last1_reg;
    logic [CW-1:0]        col1_reg;
    logic signed [15:0]   smp1_reg;
    logic signed [15:0]   above_reg;
    logic signed [15:0]   two_reg;
    logic signed [15:0]   ra_mem [0:MAX_ROW_LENGTH-1];
    logic signed [15:0]   rb_mem [0:MAX_ROW_LENGTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= height.valid;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            smp1_reg  <= height.height_in;
            col1_reg  <= col_reg;
            p1_reg    <= (col_reg >= CW'(2)) && (row_reg >= 12'd2);
            last1_reg <= (col_inc == w_eff) && (row_inc == h_eff);
        end
    end

    // line stores: read at the counter, write back one stage later
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            above_reg <= ra_mem[col_reg];
            two_reg   <= rb_mem[col_reg];
        end
        if (en && v1_reg)
        begin
            ra_mem[col1_reg] <= smp1_reg;
            rb_mem[col1_reg] <= above_reg;
        end
    end

    // window taps: 0 (c-1,r-1) 1 (c-2,r-1) 2 (c-1,r) 3 (c-1,r-2)
    logic signed [15:0] tap_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                tap_reg[i] <= '0;
        end
        else if (en && v1_reg)
        begin
            tap_reg[1] <= tap_reg[0];
            tap_reg[0] <= above_reg;
            tap_reg[3] <= two_reg;
            tap_reg[2] <= smp1_reg;
        end
    end

    // central differences
    logic signed [16:0] dx;
    logic signed [16:0] dy;

    assign dx = 17'(above_reg) - 17'(tap_reg[1]);
    assign dy = 17'(tap_reg[2]) - 17'(tap_reg[3]);

    // stage 2: magnitudes
    logic               p2_reg;
    logic [16:0]        ax_reg;
    logic [16:0]        ay_reg;
    logic [16:0]        z_reg;
    hgn_pkg::flags_t    fl2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_reg <= 1'b0;
        else if (en)
            p2_reg <= v1_reg && p1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg        <= dx[16] ? 17'(-dx) : 17'(dx);
            ay_reg        <= dy[16] ? 17'(-dy) : 17'(dy);
            z_reg         <= {gs_reg, 1'b0};
            fl2_reg.neg_x <= !dx[16] && (dx != 17'sd0);
            fl2_reg.neg_y <= !dy[16] && (dy != 17'sd0);
            fl2_reg.zero  <= (gs_reg == '0);
            fl2_reg.last  <= last1_reg;
        end
    end

    // stage 3: squares
    logic               p3_reg;
    logic [33:0]        sqx_reg;
    logic [33:0]        sqy_reg;
    logic [33:0]        sqz_reg;
    hgn_pkg::flags_t    fl3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_reg <= 1'b0;
        else if (en)
            p3_reg <= p2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
            sqz_reg <= z_reg * z_reg;
            fl3_reg <= fl2_reg;
        end
    end

    // search pipeline: slot 0 holds the start point, slot s+1 the result of step s
    hgn_pkg::comp_t         st_reg  [0:NS][0:2];
    logic signed [SW-1:0]   len_reg [0:NS];
    hgn_pkg::flags_t        fl_reg  [0:NS];
    logic signed [SW-1:0]   len2;

    assign len2 = SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);

    // one quotient bit: largest q with (2q-1)^2 * len2 <= mag^2 * 2^30
    function automatic hgn_pkg::comp_t srch_step(input hgn_pkg::comp_t c,
                                                 input logic signed [SW-1:0] len,
                                                 input int b);
        hgn_pkg::comp_t       r;
        logic [15:0]          cand;
        logic signed [SW-1:0] pc;
        logic signed [SW-1:0] mc;
        r = c;
        cand = {1'b0, c.q} | (16'd1 << b);
        pc = c.p + (c.m <<< (b + 2)) + (len <<< (2 * b + 2));
        mc = c.m + (len <<< (b + 1));
        if (cand <= 16'(hgn_pkg::ONE_Q14) && pc <= c.rhs)
        begin
            r.q = cand[hgn_pkg::Q_W-1:0];
            r.p = pc;
            r.m = mc;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (en)
            pv_reg <= {pv_reg[NS-1:0], p3_reg};
    end

    // start point: q = 0, so 2q-1 = -1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0] <= len2;
            fl_reg[0]  <= fl3_reg;
            st_reg[0][0] <= '{q: '0, p: len2, m: -len2, rhs: SW'(sqx_reg) <<< 30};
            st_reg[0][1] <= '{q: '0, p: len2, m: -len2, rhs: SW'(sqy_reg) <<< 30};
            st_reg[0][2] <= '{q: '0, p: len2, m: -len2, rhs: SW'(sqz_reg) <<< 30};
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_srch
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[s+1] <= len_reg[s];
                fl_reg[s+1]  <= fl_reg[s];
                for (int k = 0; k < 3; k++)
                    st_reg[s+1][k] <= srch_step(st_reg[s][k], len_reg[s], NS - 1 - s);
            end
        end
    end

    // output register
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic [14:0]        nz_reg;
    logic               last_reg;
    logic [15:0]        qx;
    logic [15:0]        qy;

    assign qx = 16'(st_reg[NS][0].q);
    assign qy = 16'(st_reg[NS][1].q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ld)
            out_valid_reg <= pv_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (out_ld && pv_reg[NS])
        begin
            last_reg <= fl_reg[NS].last;
            if (fl_reg[NS].zero)
            begin
                nx_reg <= '0;
                ny_reg <= '0;
                nz_reg <= hgn_pkg::ONE_Q14;
            end
            else
            begin
                nx_reg <= fl_reg[NS].neg_x ? -$signed(qx) : $signed(qx);
                ny_reg <= fl_reg[NS].neg_y ? -$signed(qy) : $signed(qy);
                nz_reg <= st_reg[NS][2].q;
            end
        end
    end

    assign normal.valid      = out_valid_reg;
    assign normal.normal_x   = nx_reg;
    assign normal.normal_y   = ny_reg;
    assign normal.normal_z   = nz_reg;
    assign normal.frame_last = last_reg;

    // checks
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !normal.ready && pv_reg[NS]) |-> !height.ready)
        else $error("sample taken while pipeline is blocked");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (nz_reg <= hgn_pkg::ONE_Q14))
        else $error("normal_z above one");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (LW'(col_reg) < w_eff) && (LW'(row_reg) < h_eff))
        else $error("position counter out of range");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !normal.ready && pv_reg[NS]) |=> $stable(pv_reg))
        else $error("search pipeline moved during stall");

endmodule
